FILE: src/ppf_pkg.sv
// shared types and constants for the paeth predictive filter
package ppf_pkg;

    localparam int MaxWidth   = 4096;
    localparam int ColW       = $clog2(MaxWidth);
    localparam int SampleW    = 8;
    localparam int CfgWidthW  = 13;
    localparam int CfgHeightW = 16;
    localparam int CfgDataW   = 16;
    localparam int CfgIdxW    = 2;
    localparam int CmpW       = (ColW + 1 > CfgWidthW) ? ColW + 1 : CfgWidthW;
    localparam int QDepth     = 2;
    localparam int QPtrW      = $clog2(QDepth);
    localparam int QCntW      = $clog2(QDepth + 1);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_MODE   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [SampleW-1:0] sample;
        logic [ColW-1:0]    col;
        logic               pass;
        logic               last;
    } ppf_item_t;

endpackage

FILE: src/ppf_front.sv
// front end: configuration registers, raster counters and item classification
module ppf_front
    import ppf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SampleW-1:0]  sample_in,
    input  logic                cfg_valid,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic                q_full,
    output logic                push,
    output ppf_item_t           push_item,
    output logic                decode_mode
);

    logic [CfgWidthW-1:0]  width_reg;
    logic [CfgHeightW-1:0] height_reg;
    logic                  mode_reg;
    logic [ColW-1:0]       col_reg, col_next;
    logic [CfgHeightW-1:0] row_reg, row_next;

    logic [CmpW-1:0]       eff_width;
    logic [CmpW-1:0]       col_inc;
    logic [CfgHeightW-1:0] eff_height;
    logic [CfgHeightW:0]   row_inc;
    logic                  col_wrap;
    logic                  row_wrap;

    assign in_ready    = !q_full;
    assign push        = in_valid && in_ready;
    assign decode_mode = mode_reg;

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_width = CmpW'(1);
        end
        else if (CmpW'(width_reg) > CmpW'(MaxWidth))
        begin
            eff_width = CmpW'(MaxWidth);
        end
        else
        begin
            eff_width = CmpW'(width_reg);
        end
        eff_height = (height_reg == '0) ? CfgHeightW'(1) : height_reg;
        col_inc    = CmpW'(col_reg) + CmpW'(1);
        row_inc    = {1'b0, row_reg} + (CfgHeightW + 1)'(1);
        col_wrap   = col_inc >= eff_width;
        row_wrap   = col_wrap && (row_inc >= {1'b0, eff_height});

        push_item.sample = sample_in;
        push_item.col    = col_reg;
        push_item.pass   = (row_reg == '0) || (col_reg == '0);
        push_item.last   = row_wrap;

        col_next = col_wrap ? '0 : col_inc[ColW-1:0];
        if (!col_wrap)
        begin
            row_next = row_reg;
        end
        else if (row_wrap)
        begin
            row_next = '0;
        end
        else
        begin
            row_next = row_inc[CfgHeightW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CfgWidthW'(4096);
            height_reg <= CfgHeightW'(1);
            mode_reg   <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_WIDTH:  width_reg  <= cfg_data[CfgWidthW-1:0];
                    CFG_HEIGHT: height_reg <= cfg_data[CfgHeightW-1:0];
                    CFG_MODE:   mode_reg   <= cfg_data[0];
                    default:    ;
                endcase
            end
            if (push)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

endmodule

FILE: src/ppf_queue.sv
// short fifo between the front end and the predictor back end
module ppf_queue
    import ppf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ppf_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      q_valid,
    output ppf_item_t q_item
);

    ppf_item_t        entry_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg;
    logic [QPtrW-1:0] rd_ptr_reg;
    logic [QCntW-1:0] count_reg, count_next;

    assign full    = count_reg == QCntW'(QDepth);
    assign q_valid = count_reg != '0;
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + QPtrW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + QPtrW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCntW'(QDepth))
        else $error("queue count out of range");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> !pop)
        else $error("pop from empty queue");

endmodule

FILE: src/ppf_back.sv
// back end: line store, paeth predictor and output register
module ppf_back
    import ppf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  ppf_item_t          q_item,
    output logic               pop,
    input  logic               decode_mode,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SampleW-1:0] sample_out,
    output logic               plane_end
);

    logic [SampleW-1:0] row_mem [MaxWidth];
    logic [SampleW-1:0] mem_rd_reg;

    logic               a_valid_reg;
    ppf_item_t          a_item_reg;
    logic               fwd_reg;
    logic [SampleW-1:0] fwd_data_reg;
    logic [SampleW-1:0] left_reg;
    logic [SampleW-1:0] upper_left_reg;

    logic               out_valid_reg;
    logic [SampleW-1:0] sample_out_reg;
    logic               plane_end_reg;

    logic               a_move;
    logic               a_take;
    logic [SampleW-1:0] above;
    logic [SampleW-1:0] pred;
    logic [SampleW-1:0] result;
    logic [SampleW-1:0] keep;

    function automatic logic [SampleW-1:0] paeth(
        input logic [SampleW-1:0] a,
        input logic [SampleW-1:0] b,
        input logic [SampleW-1:0] c
    );
        logic signed [SampleW+2:0] da_s;
        logic signed [SampleW+2:0] db_s;
        logic signed [SampleW+2:0] dc_s;
        logic [SampleW+1:0]        da;
        logic [SampleW+1:0]        db;
        logic [SampleW+1:0]        dc;
        // distances of a + b - c to a, b and c
        da_s = $signed({3'b000, b}) - $signed({3'b000, c});
        db_s = $signed({3'b000, a}) - $signed({3'b000, c});
        dc_s = da_s + db_s;
        da   = da_s[SampleW+2] ? (SampleW + 2)'(-da_s) : da_s[SampleW+1:0];
        db   = db_s[SampleW+2] ? (SampleW + 2)'(-db_s) : db_s[SampleW+1:0];
        dc   = dc_s[SampleW+2] ? (SampleW + 2)'(-dc_s) : dc_s[SampleW+1:0];
        if (da <= db && da <= dc)
        begin
            return a;
        end
        else if (db <= dc)
        begin
            return b;
        end
        return c;
    endfunction

    assign a_move     = a_valid_reg && (!out_valid_reg || out_ready);
    assign a_take     = q_valid && (!a_valid_reg || a_move);
    assign pop        = a_take;
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign plane_end  = plane_end_reg;

    always_comb
    begin
        above = fwd_reg ? fwd_data_reg : mem_rd_reg;
        pred  = paeth(left_reg, above, upper_left_reg);
        if (a_item_reg.pass)
        begin
            result = a_item_reg.sample;
            keep   = a_item_reg.sample;
        end
        else if (decode_mode)
        begin
            result = a_item_reg.sample + pred;
            keep   = result;
        end
        else
        begin
            result = a_item_reg.sample - pred;
            keep   = a_item_reg.sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            fwd_reg        <= 1'b0;
            left_reg       <= '0;
            upper_left_reg <= '0;
        end
        else
        begin
            if (a_take)
            begin
                a_valid_reg <= 1'b1;
                // same column still being written by the item ahead
                fwd_reg     <= a_move && (q_item.col == a_item_reg.col);
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_move)
            begin
                out_valid_reg  <= 1'b1;
                left_reg       <= keep;
                upper_left_reg <= above;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take)
        begin
            a_item_reg   <= q_item;
            fwd_data_reg <= keep;
        end
        if (a_move)
        begin
            sample_out_reg <= result;
            plane_end_reg  <= a_item_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            row_mem[a_item_reg.col] <= keep;
        end
        if (a_take)
        begin
            mem_rd_reg <= row_mem[q_item.col];
        end
    end

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        a_take |=> a_valid_reg)
        else $error("stage not loaded after take");

    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        (a_move && a_item_reg.pass) |=> (sample_out_reg == $past(a_item_reg.sample)))
        else $error("edge sample not passed through");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !a_move)
        else $error("result overwritten while stalled");

endmodule

FILE: src/paeth_predictive_filter_unit.sv
// top level of the paeth predictive filter
//
//  channel   direction  signals
//  ------    ---------  -------------------------------------------
//  input     in         in_valid, in_ready, sample_in
//  output    out        out_valid, out_ready, sample_out, plane_end
//  config    in         cfg_valid, cfg_ready, cfg_index, cfg_data
//
// one sample per cycle sustained while out_ready stays high; an input transfer passes the queue
// entry, the stage register with the registered line store read and the output register
// a two-entry queue separates the counters from the predictor so either side stalls alone
// reset clears counters and neighbour registers, resets the config; the line store is not cleared
// config writes are always taken; the mode is applied in the back end, so write only when
// no sample is in flight
module paeth_predictive_filter_unit
    import ppf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SampleW-1:0]  sample_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SampleW-1:0]  sample_out,
    output logic                plane_end,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    logic      push;
    ppf_item_t push_item;
    logic      q_full;
    logic      pop;
    logic      q_valid;
    ppf_item_t q_item;
    logic      decode_mode;

    assign cfg_ready = 1'b1;

    ppf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_in   (sample_in),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item),
        .decode_mode (decode_mode)
    );

    ppf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    ppf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .pop         (pop),
        .decode_mode (decode_mode),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample_out  (sample_out),
        .plane_end   (plane_end)
    );

endmodule

FILE: tb/paeth_predictive_filter_unit_tb.sv
// testbench for the paeth predictive filter unit: directed table, random planes, scoreboard
`timescale 1ns / 1ps

module paeth_predictive_filter_unit_tb;
    import ppf_pkg::*;

    localparam logic [CfgIdxW-1:0] CFG_NONE = 2'd3;
    localparam int RandItems = 1250;
    localparam int QuietItems = 150;
    localparam int WidthMask = (1 << CfgWidthW) - 1;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;
    typedef enum {MIX_NOISE, MIX_SMOOTH, MIX_EDGES} mix_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [CfgIdxW-1:0] idx;
        logic [CfgDataW-1:0] data;
        logic [SampleW-1:0] smp;
        logic               fixed;
        logic [SampleW-1:0] exp_smp;
        logic               exp_end;
    } dir_row_t;

    typedef struct packed {
        logic [SampleW-1:0] smp;
        logic               last;
    } filt_out_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [SampleW-1:0]  sample_in;
    logic                out_valid;
    logic                out_ready;
    logic [SampleW-1:0]  sample_out;
    logic                plane_end;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    // typed expectation travels with the sample transfer
    logic               fix_valid;
    logic [SampleW-1:0] fix_smp;
    logic               fix_end;

    // predictor state
    bit [SampleW-1:0] line_mem [MaxWidth];
    bit               line_set [MaxWidth];
    int               line_extent = 0;
    logic [SampleW-1:0] left_px = '0;
    logic [SampleW-1:0] upleft_px = '0;
    int               col_cnt = 0;
    int               row_cnt = 0;
    int               cfg_w = MaxWidth;
    int               cfg_h = 1;
    bit               dec_mode = 1'b0;

    filt_out_t pend_out[$];
    int        err_cnt = 0;
    int        seen_cnt = 0;
    bit        idle_on = 1'b1;
    bit        quiet = 1'b0;
    bit        press = 1'b0;
    bit        cfg_open = 1'b0;
    logic [SampleW-1:0] last_smp = '0;

    dir_row_t dir_tab [0:35];

    paeth_predictive_filter_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .plane_end  (plane_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int eff_width(int v);
        if (v == 0)
            return 1;
        if (v > MaxWidth)
            return MaxWidth;
        return v;
    endfunction

    function automatic logic [SampleW-1:0] paeth_pick(logic [SampleW-1:0] a,
                                                     logic [SampleW-1:0] b,
                                                     logic [SampleW-1:0] c);
        int p;
        int da;
        int db;
        int dc;
        p = int'(a) + int'(b) - int'(c);
        da = (p >= int'(a)) ? p - int'(a) : int'(a) - p;
        db = (p >= int'(b)) ? p - int'(b) : int'(b) - p;
        dc = (p >= int'(c)) ? p - int'(c) : int'(c) - p;
        if (da <= db && da <= dc)
            return a;
        if (db <= dc)
            return b;
        return c;
    endfunction

    function automatic filt_out_t filter_step(logic [SampleW-1:0] s);
        filt_out_t res;
        int w;
        int h;
        int x;
        logic [SampleW-1:0] above;
        logic [SampleW-1:0] keep;
        w = eff_width(cfg_w);
        h = (cfg_h == 0) ? 1 : cfg_h;
        x = col_cnt;
        above = line_mem[x];
        if (row_cnt == 0 || x == 0)
        begin
            res.smp = s;
            keep = s;
        end
        else if (dec_mode)
        begin
            res.smp = s + paeth_pick(left_px, above, upleft_px);
            keep = res.smp;
        end
        else
        begin
            res.smp = s - paeth_pick(left_px, above, upleft_px);
            keep = s;
        end
        line_mem[x] = keep;
        line_set[x] = 1'b1;
        while (line_extent < MaxWidth && line_set[line_extent])
            line_extent++;
        upleft_px = above;
        left_px = keep;
        res.last = 1'b0;
        x++;
        if (x >= w)
        begin
            x = 0;
            row_cnt++;
            if (row_cnt >= h)
            begin
                row_cnt = 0;
                res.last = 1'b1;
            end
        end
        col_cnt = x;
        return res;
    endfunction

    function automatic logic [SampleW-1:0] pick_sample(mix_t mix);
        logic [SampleW-1:0] s;
        case (mix)
            MIX_SMOOTH:
                if ($urandom_range(0, 15) == 0)
                    s = 8'($urandom_range(0, 255));
                else
                    s = last_smp + 8'($urandom_range(0, 6)) - 8'd3;
            MIX_EDGES:
                if ($urandom_range(0, 3) == 0)
                    s = 8'($urandom_range(0, 255));
                else
                    s = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:
                s = 8'($urandom_range(0, 255));
        endcase
        last_smp = s;
        return s;
    endfunction

    // scoreboard: predictor on config writes and input transfers, check on output transfers
    always @(posedge clk)
    begin
        filt_out_t want;
        filt_out_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WIDTH:  cfg_w = int'(cfg_data[CfgWidthW-1:0]);
                    CFG_HEIGHT: cfg_h = int'(cfg_data[CfgHeightW-1:0]);
                    CFG_MODE:   dec_mode = cfg_data[0];
                    default:    ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                want = filter_step(sample_in);
                if (fix_valid)
                begin
                    want.smp = fix_smp;
                    want.last = fix_end;
                end
                pend_out.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                got.smp = sample_out;
                got.last = plane_end;
                seen_cnt++;
                if (pend_out.size() == 0)
                begin
                    if (err_cnt < 10)
                        $display("unexpected transfer: sample_out %02h plane_end %0d",
                                 got.smp, got.last);
                    err_cnt++;
                end
                else
                begin
                    want = pend_out.pop_front();
                    if (got.smp !== want.smp || got.last !== want.last)
                    begin
                        if (err_cnt < 10)
                            $display("mismatch at result %0d: sample_out exp %02h got %02h, %s%0d %s%0d",
                                     seen_cnt, want.smp, got.smp,
                                     "plane_end exp ", want.last, "got ", got.last);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // receiver with random stall bursts and one long hold-off
    initial
    begin
        int  stall_left;
        int  window;
        bit  choppy;
        bit  held;
        stall_left = 0;
        window = 0;
        choppy = 1'b0;
        held = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && press)
            begin
                held = 1'b1;
                stall_left = 400;
            end
            else if (stall_left == 0)
            begin
                if (window == 0)
                begin
                    window = $urandom_range(16, 160);
                    choppy = ($urandom_range(0, 2) != 0);
                end
                window--;
                if (choppy && !quiet && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 14);
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic drain_out();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pend_out.size() != 0);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_open = 1'b1;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic push_sample(input logic [SampleW-1:0] s, input logic fixed,
                               input logic [SampleW-1:0] exp_smp, input logic exp_end);
        if (cfg_open)
        begin
            cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        in_valid <= 1'b1;
        sample_in <= s;
        fix_valid <= fixed;
        fix_smp <= exp_smp;
        fix_end <= exp_end;
        do
            @(posedge clk);
        while (!in_ready);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    initial
    begin
        int   sent;
        int   n;
        int   r;
        int   val;
        int   phase;
        mix_t mix;

        dir_tab = '{
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'h00, 1'b1, 8'h00, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'hFF, 1'b1, 8'hFF, 1'b0},
            '{ROW_CFG,    CFG_WIDTH,  16'h0000, 8'h00, 1'b0, 8'h00, 1'b0},
            '{ROW_CFG,    CFG_HEIGHT, 16'h0000, 8'h00, 1'b0, 8'h00, 1'b0},
            '{ROW_CFG,    CFG_NONE,   16'hFFFF, 8'h00, 1'b0, 8'h00, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'hA5, 1'b1, 8'hA5, 1'b1},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'h5A, 1'b1, 8'h5A, 1'b1},
            '{ROW_CFG,    CFG_WIDTH,  16'h0003, 8'h00, 1'b0, 8'h00, 1'b0},
            '{ROW_CFG,    CFG_HEIGHT, 16'h0003, 8'h00, 1'b0, 8'h00, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'd10, 1'b1, 8'd10, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'd20, 1'b1, 8'd20, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'd30, 1'b1, 8'd30, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'd40, 1'b1, 8'd40, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'hFF, 1'b0, 8'h00, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'h00, 1'b0, 8'h00, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'h00, 1'b1, 8'h00, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'h80, 1'b0, 8'h00, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'hFF, 1'b0, 8'h00, 1'b0},
            '{ROW_CFG,    CFG_MODE,   16'h0001, 8'h00, 1'b0, 8'h00, 1'b0},
            '{ROW_CFG,    CFG_WIDTH,  16'h0002, 8'h00, 1'b0, 8'h00, 1'b0},
            '{ROW_CFG,    CFG_HEIGHT, 16'h0002, 8'h00, 1'b0, 8'h00, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'd7,  1'b1, 8'd7,  1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'd200, 1'b1, 8'd200, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'd3,  1'b1, 8'd3,  1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'hFF, 1'b0, 8'h00, 1'b0},
            '{ROW_CFG,    CFG_WIDTH,  16'h1FFF, 8'h00, 1'b0, 8'h00, 1'b0},
            '{ROW_CFG,    CFG_HEIGHT, 16'hFFFF, 8'h00, 1'b0, 8'h00, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'd1,  1'b1, 8'd1,  1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'd2,  1'b1, 8'd2,  1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'd3,  1'b1, 8'd3,  1'b0},
            '{ROW_CFG,    CFG_WIDTH,  16'h0002, 8'h00, 1'b0, 8'h00, 1'b0},
            '{ROW_CFG,    CFG_MODE,   16'h0000, 8'h00, 1'b0, 8'h00, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'h80, 1'b1, 8'h80, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'h11, 1'b1, 8'h11, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'hEE, 1'b0, 8'h00, 1'b0},
            '{ROW_SAMPLE, CFG_WIDTH,  16'h0000, 8'h33, 1'b1, 8'h33, 1'b0}
        };

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        sample_in <= '0;
        fix_valid <= 1'b0;
        fix_smp <= '0;
        fix_end <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_WIDTH;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < $size(dir_tab); i++)
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                if (!cfg_open)
                    drain_out();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end
            else
                push_sample(dir_tab[i].smp, dir_tab[i].fixed,
                            dir_tab[i].exp_smp, dir_tab[i].exp_end);
        end

        // random planes
        sent = 0;
        phase = 0;
        while (sent < RandItems)
        begin
            drain_out();
            mix = mix_t'($urandom_range(0, 2));
            if (phase == 2)
            begin
                // close the current plane with one sample, then start a saturated-width plane
                if (row_cnt != 0 || col_cnt != 0)
                begin
                    write_reg(CFG_HEIGHT, 16'd1);
                    write_reg(CFG_WIDTH, 16'd1);
                    push_sample(pick_sample(mix), 1'b0, '0, 1'b0);
                    drain_out();
                end
                write_reg(CFG_WIDTH, 16'($urandom_range(MaxWidth, WidthMask)));
                write_reg(CFG_HEIGHT, 16'd2);
                write_reg(CFG_MODE, 16'($urandom_range(0, 1)));
                n = $urandom_range(16, 64);
            end
            else
            begin
                if ($urandom_range(0, 1))
                begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        val = $urandom_range(1, 16);
                    else if (r < 78)
                        val = $urandom_range(17, 300);
                    else if (r < 84)
                        val = 0;
                    else if (r < 90)
                        val = $urandom_range(1, 16) | ($urandom_range(1, 7) << CfgWidthW);
                    else if (r < 95)
                        val = MaxWidth;
                    else
                        val = $urandom_range(MaxWidth + 1, WidthMask);
                    // no growth past the written part of the line store mid-plane
                    if (eff_width(val & WidthMask) > line_extent &&
                        !(row_cnt == 0 && col_cnt <= line_extent))
                        val = line_extent;
                    write_reg(CFG_WIDTH, 16'(val));
                end
                if ($urandom_range(0, 1))
                begin
                    r = $urandom_range(0, 99);
                    if (r < 60)
                        val = $urandom_range(1, 6);
                    else if (r < 70)
                        val = 0;
                    else if (r < 75)
                        val = 65535;
                    else if (r < 88)
                        val = $urandom_range(7, 40);
                    else
                        val = $urandom_range(0, 65535);
                    write_reg(CFG_HEIGHT, 16'(val));
                end
                if ($urandom_range(0, 1))
                    write_reg(CFG_MODE, 16'($urandom_range(0, 65535)));
                n = $urandom_range(8, 80);
            end
            // long receiver hold-off while this batch keeps offering
            if (sent >= 300)
                press = 1'b1;
            idle_on = !quiet && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < n; k++)
            begin
                if (phase != 2)
                begin
                    if (sent >= RandItems - QuietItems)
                    begin
                        quiet = 1'b1;
                        idle_on = 1'b0;
                    end
                    sent++;
                end
                push_sample(pick_sample(mix), 1'b0, '0, 1'b0);
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (pend_out.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (err_cnt == 0 && pend_out.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: paeth_predictive_filter_unit.f
src/ppf_pkg.sv
src/ppf_front.sv
src/ppf_queue.sv
src/ppf_back.sv
src/paeth_predictive_filter_unit.sv
tb/paeth_predictive_filter_unit_tb.sv
